>>> src/point_in_polygon_with_holes_core_assert.svh
// Assertion macros shared by the checker of point_in_polygon_with_holes_core.
// Depends on nothing; included by the checker file by its bare file name.
`ifndef POINT_IN_POLYGON_WITH_HOLES_CORE_ASSERT_SVH
`define POINT_IN_POLYGON_WITH_HOLES_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIPWH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PIPWH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pipwh_pkg.sv
// Shared types for the point-in-polygon-with-holes core.
// No dependencies; used by the top level and its checker.
package pipwh_pkg;

  // One result transaction: the finished ring's answer, the sector answer and the sector-done flag.
  typedef struct packed {
    logic ring_inside;
    logic sector_inside;
    logic sector_done;
  } result_t;

endpackage

>>> src/pipwh_ifs.sv
// Valid/ready channel interfaces for the point-in-polygon-with-holes core.
// The vertex channel is sized by COORD_BITS; no other dependencies.
interface pipwh_vertex_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         ring_last;
  logic                         sector_last;

  modport source (
    output valid, vertex_x, vertex_y, point_x, point_y, ring_last, sector_last,
    input  ready
  );
  modport sink (
    input  valid, vertex_x, vertex_y, point_x, point_y, ring_last, sector_last,
    output ready
  );
endinterface

interface pipwh_result_if;
  logic valid;
  logic ready;
  logic ring_inside;
  logic sector_inside;
  logic sector_done;

  modport source (
    output valid, ring_inside, sector_inside, sector_done,
    input  ready
  );
  modport sink (
    input  valid, ring_inside, sector_inside, sector_done,
    output ready
  );
endinterface

>>> src/pipwh_edge.sv
// Exact ray-crossing test of one polygon edge against a query point.
// Combinational, sized by COORD_BITS; no package dependencies.
module pipwh_edge #(
  parameter int COORD_BITS = 24
) (
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  output logic                         crosses
);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] d;
  logic signed [DW-1:0] dpx;
  logic signed [DW-1:0] dbx;
  logic signed [DW-1:0] dpy;
  logic signed [PW-1:0] lhs;
  logic signed [PW-1:0] rhs;
  logic                 straddle;

  // Differences grow by one bit, products are exact, so no rounding anywhere.
  assign d   = {by[COORD_BITS-1], by} - {ay[COORD_BITS-1], ay};
  assign dpx = {px[COORD_BITS-1], px} - {ax[COORD_BITS-1], ax};
  assign dbx = {bx[COORD_BITS-1], bx} - {ax[COORD_BITS-1], ax};
  assign dpy = {py[COORD_BITS-1], py} - {ay[COORD_BITS-1], ay};

  assign lhs = PW'(dpx) * PW'(d);
  assign rhs = PW'(dbx) * PW'(dpy);

  // The edge counts only when its end points lie on opposite sides of the ray;
  // d is then nonzero and its sign decides the direction of the compare.
  assign straddle = (ay > py) != (by > py);
  assign crosses  = straddle && (d[DW-1] ? (lhs > rhs) : (lhs < rhs));
endmodule

>>> src/point_in_polygon_with_holes_core.sv
// Point-in-polygon-with-holes core: streaming crossing-number test.
// Depends on pipwh_pkg, the channel interfaces in pipwh_ifs.sv and pipwh_edge.
//
// The core takes the vertices of a sector one transaction per vertex on in_if:
// the outer ring first, then any hole rings, the last vertex of each ring
// flagged by ring_last and the last ring of the sector also by sector_last.
// Every vertex carries the query point, and each vertex is tested against the
// point given with it. Coordinates are signed fixed point (Q16.8 at the default
// COORD_BITS of 24). For each ring the core keeps the bounding box, whether the
// point equals a vertex, and the parity of edge crossings of a ray from the
// point toward +x, including the closing edge back to the first vertex. Edge
// tests are exact cross-multiplications. A ring reports inside only if the
// crossing parity is odd, no vertex equals the point, and the point lies in
// the box. Each ring-end vertex produces one result transaction on out_if with
// ring_inside, sector_inside (outer ring inside and no hole inside so far) and
// sector_done. Vertices that do not end a ring produce nothing. Throughput is
// one vertex per clock while no ring-end vertex stalls: the per-vertex state
// update (two exact edge tests running in parallel, then the box and parity
// update) is combinational. A ring-end vertex waits in the input register
// until it is processed; its result is then written into the result register
// and is valid on out_if from then on. The result register lets vertices keep
// flowing while a result waits; only a ring-end vertex stalls, and only when
// an untaken result still occupies the result register. There is no clearing
// pass after reset. The COORD_BITS parameter must match the one on the vertex
// channel interface.
module point_in_polygon_with_holes_core #(
  parameter int COORD_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pipwh_vertex_if.sink          in_if,
  pipwh_result_if.source        out_if
);

  // Input register stage. The payload needs no reset.
  logic                         s1_valid_r;
  logic signed [COORD_BITS-1:0] s1_vx_r;
  logic signed [COORD_BITS-1:0] s1_vy_r;
  logic signed [COORD_BITS-1:0] s1_px_r;
  logic signed [COORD_BITS-1:0] s1_py_r;
  logic                         s1_rlast_r;
  logic                         s1_slast_r;

  // Per-ring and per-sector state.
  logic signed [COORD_BITS-1:0] first_x_r, first_y_r;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r;
  logic signed [COORD_BITS-1:0] box_min_x_r, box_max_x_r;
  logic signed [COORD_BITS-1:0] box_min_y_r, box_max_y_r;
  logic                         parity_r;
  logic                         hit_r;
  logic                         ring_start_r;
  logic                         outer_r;
  logic                         sector_r;

  // Result register.
  logic                         out_valid_r;
  pipwh_pkg::result_t           out_r;

  // Next values.
  logic signed [COORD_BITS-1:0] first_x_nxt, first_y_nxt;
  logic signed [COORD_BITS-1:0] box_min_x_nxt, box_max_x_nxt;
  logic signed [COORD_BITS-1:0] box_min_y_nxt, box_max_y_nxt;
  logic                         parity_mid;
  logic                         parity_end;
  logic                         hit_mid;
  logic                         ring_in;
  logic                         sector_nxt;
  logic                         out_valid_nxt;
  pipwh_pkg::result_t           out_nxt;

  logic                         edge_cross;
  logic                         close_cross;
  logic                         proc;

  // The vertex in the input register is processed this cycle unless it ends a
  // ring and the result register still holds a result that was not taken.
  assign proc        = s1_valid_r && (!s1_rlast_r || !out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || proc;

  // Edge from this vertex to the previous one, meaningful only inside a ring.
  pipwh_edge #(.COORD_BITS(COORD_BITS)) u_edge_prev (
    .ax      (s1_vx_r),
    .ay      (s1_vy_r),
    .bx      (prev_x_r),
    .by      (prev_y_r),
    .px      (s1_px_r),
    .py      (s1_py_r),
    .crosses (edge_cross)
  );

  // Closing edge from the ring's first vertex to this vertex. On a one-vertex
  // ring both ends coincide and the test yields no crossing.
  pipwh_edge #(.COORD_BITS(COORD_BITS)) u_edge_close (
    .ax      (first_x_nxt),
    .ay      (first_y_nxt),
    .bx      (s1_vx_r),
    .by      (s1_vy_r),
    .px      (s1_px_r),
    .py      (s1_py_r),
    .crosses (close_cross)
  );

  always_comb begin
    if (ring_start_r) begin
      first_x_nxt   = s1_vx_r;
      first_y_nxt   = s1_vy_r;
      box_min_x_nxt = s1_vx_r;
      box_max_x_nxt = s1_vx_r;
      box_min_y_nxt = s1_vy_r;
      box_max_y_nxt = s1_vy_r;
      parity_mid    = 1'b0;
      hit_mid       = 1'b0;
    end else begin
      first_x_nxt   = first_x_r;
      first_y_nxt   = first_y_r;
      box_min_x_nxt = (s1_vx_r < box_min_x_r) ? s1_vx_r : box_min_x_r;
      box_max_x_nxt = (s1_vx_r > box_max_x_r) ? s1_vx_r : box_max_x_r;
      box_min_y_nxt = (s1_vy_r < box_min_y_r) ? s1_vy_r : box_min_y_r;
      box_max_y_nxt = (s1_vy_r > box_max_y_r) ? s1_vy_r : box_max_y_r;
      parity_mid    = parity_r ^ edge_cross;
      hit_mid       = hit_r;
    end
    if ((s1_vx_r == s1_px_r) && (s1_vy_r == s1_py_r)) begin
      hit_mid = 1'b1;
    end

    parity_end = parity_mid ^ close_cross;
    ring_in    = parity_end && !hit_mid &&
                 (s1_px_r >= box_min_x_nxt) && (s1_px_r <= box_max_x_nxt) &&
                 (s1_py_r >= box_min_y_nxt) && (s1_py_r <= box_max_y_nxt);

    // The outer ring sets the sector answer; an enclosing hole clears it.
    if (outer_r) begin
      sector_nxt = ring_in;
    end else if (ring_in) begin
      sector_nxt = 1'b0;
    end else begin
      sector_nxt = sector_r;
    end

    out_nxt.ring_inside   = ring_in;
    out_nxt.sector_inside = sector_nxt;
    out_nxt.sector_done   = s1_slast_r;

    if (proc && s1_rlast_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state and valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      first_x_r    <= '0;
      first_y_r    <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      box_min_x_r  <= '0;
      box_max_x_r  <= '0;
      box_min_y_r  <= '0;
      box_max_y_r  <= '0;
      parity_r     <= 1'b0;
      hit_r        <= 1'b0;
      ring_start_r <= 1'b1;
      outer_r      <= 1'b1;
      sector_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_if.valid && in_if.ready) begin
        s1_valid_r <= 1'b1;
      end else if (proc) begin
        s1_valid_r <= 1'b0;
      end
      if (proc) begin
        first_x_r   <= first_x_nxt;
        first_y_r   <= first_y_nxt;
        prev_x_r    <= s1_vx_r;
        prev_y_r    <= s1_vy_r;
        box_min_x_r <= box_min_x_nxt;
        box_max_x_r <= box_max_x_nxt;
        box_min_y_r <= box_min_y_nxt;
        box_max_y_r <= box_max_y_nxt;
        if (s1_rlast_r) begin
          ring_start_r <= 1'b1;
          parity_r     <= 1'b0;
          hit_r        <= 1'b0;
          outer_r      <= s1_slast_r;
          sector_r     <= sector_nxt;
        end else begin
          ring_start_r <= 1'b0;
          parity_r     <= parity_mid;
          hit_r        <= hit_mid;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_vx_r    <= in_if.vertex_x;
      s1_vy_r    <= in_if.vertex_y;
      s1_px_r    <= in_if.point_x;
      s1_py_r    <= in_if.point_y;
      s1_rlast_r <= in_if.ring_last;
      s1_slast_r <= in_if.sector_last;
    end
    if (proc && s1_rlast_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.ring_inside   = out_r.ring_inside;
  assign out_if.sector_inside = out_r.sector_inside;
  assign out_if.sector_done   = out_r.sector_done;

endmodule

>>> src/pipwh_checker.sv
// Port-level checker for point_in_polygon_with_holes_core, bound to the top.
// Depends on pipwh_pkg and point_in_polygon_with_holes_core_assert.svh.
`include "point_in_polygon_with_holes_core_assert.svh"

module pipwh_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic ring_inside,
  input logic sector_inside,
  input logic sector_done
);
  pipwh_pkg::result_t res;
  logic               out_fire;
  logic               outer_next_r;
  logic               prev_sector_r;

  assign res.ring_inside   = ring_inside;
  assign res.sector_inside = sector_inside;
  assign res.sector_done   = sector_done;
  assign out_fire          = out_valid && out_ready;

  // Tracks whether the next result belongs to an outer ring.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_next_r  <= 1'b1;
      prev_sector_r <= 1'b0;
    end else if (out_fire) begin
      outer_next_r  <= sector_done;
      prev_sector_r <= sector_inside;
    end
  end

  `PIPWH_ASSERT_NEXT(a_out_valid_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result valid dropped while stalled")
  `PIPWH_ASSERT_NEXT(a_out_payload_hold, clk, rst_n, out_valid && !out_ready, $stable(res), "result changed while stalled")
  `PIPWH_ASSERT_NOW(a_outer_sets_sector, clk, rst_n, out_fire && outer_next_r, sector_inside == ring_inside, "outer ring answer not taken as sector answer")
  `PIPWH_ASSERT_NOW(a_hole_clears_sector, clk, rst_n, out_fire && !outer_next_r && ring_inside, !sector_inside, "enclosing hole did not clear sector answer")
  `PIPWH_ASSERT_NOW(a_hole_never_sets, clk, rst_n, out_fire && !outer_next_r && sector_inside, prev_sector_r, "hole ring raised the sector answer")

endmodule

bind point_in_polygon_with_holes_core pipwh_checker u_pipwh_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .ring_inside   (out_if.ring_inside),
  .sector_inside (out_if.sector_inside),
  .sector_done   (out_if.sector_done)
);

>>> tb/point_in_polygon_with_holes_core_tb.sv
// Self-checking testbench for point_in_polygon_with_holes_core.
// Needs pipwh_pkg, the channel interfaces of pipwh_ifs.sv and the core itself.
// Directed sectors come first, then random sectors, under random stalls on both sides.
`timescale 1ns / 100ps

module point_in_polygon_with_holes_core_tb;

  localparam int CW           = 24;
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_ITEMS = 600;
  localparam int DRAIN_CYCLES = 10;
  // The slowest correct run is roughly 650 vertices, each delayed by a random source gap
  // and a random sink stall. CYCLE_LIMIT lies well above the total that this gives.
  localparam int CYCLE_LIMIT  = 400000;

  // The shapes of ring that the random sectors are built from.
  typedef enum int {
    RING_RECT,
    RING_SCATTER,
    RING_WILD,
    RING_TINY
  } ring_kind_t;

  // One vertex transaction as the source drives it.
  typedef struct {
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic                 ring_last;
    logic                 sector_last;
  } vertex_t;

  // The class predicts the ring and sector answers from the accepted vertices.
  // It queues those answers and checks each result transaction against the oldest one.
  class ring_scoreboard;
    logic signed [CW-1:0] first_x, first_y;
    logic signed [CW-1:0] prev_x, prev_y;
    logic signed [CW-1:0] min_x, max_x, min_y, max_y;
    bit                   parity, hit, ring_start, outer, sector_res;
    pipwh_pkg::result_t   pending[$];
    int                   mismatches, results, rings_inside, sectors;

    function new();
      first_x = '0; first_y = '0; prev_x = '0; prev_y = '0;
      min_x = '0; max_x = '0; min_y = '0; max_y = '0;
      parity = 1'b0; hit = 1'b0; ring_start = 1'b1; outer = 1'b1; sector_res = 1'b0;
      mismatches = 0; results = 0; rings_inside = 0; sectors = 0;
    endfunction

    // The ray from (px,py) toward +x crosses edge a-b. Exact, by cross-multiplication.
    function bit ray_crosses(longint ax, longint ay, longint bx, longint by,
                             longint px, longint py);
      longint d, lhs, rhs;
      if ((ay > py) == (by > py)) return 1'b0;
      d   = by - ay;
      lhs = (px - ax) * d;
      rhs = (bx - ax) * (py - ay);
      return (d > 0) ? (lhs < rhs) : (lhs > rhs);
    endfunction

    function void note_vertex(vertex_t v);
      bit                 ring_in;
      pipwh_pkg::result_t answer;
      if (ring_start) begin
        first_x = v.vx; first_y = v.vy;
        min_x = v.vx; max_x = v.vx; min_y = v.vy; max_y = v.vy;
        parity = 1'b0;
        hit = 1'b0;
      end else begin
        if (v.vx < min_x) min_x = v.vx;
        if (v.vx > max_x) max_x = v.vx;
        if (v.vy < min_y) min_y = v.vy;
        if (v.vy > max_y) max_y = v.vy;
        if (ray_crosses(v.vx, v.vy, prev_x, prev_y, v.px, v.py)) parity = ~parity;
      end
      if (v.vx == v.px && v.vy == v.py) hit = 1'b1;
      prev_x = v.vx;
      prev_y = v.vy;
      ring_start = 1'b0;
      if (!v.ring_last) return;

      // Closing edge from the ring's last vertex back to its first.
      if (ray_crosses(first_x, first_y, v.vx, v.vy, v.px, v.py)) parity = ~parity;
      ring_in = parity && !hit && v.px >= min_x && v.px <= max_x &&
                v.py >= min_y && v.py <= max_y;
      if (outer) sector_res = ring_in;
      else if (ring_in) sector_res = 1'b0;

      answer.ring_inside   = ring_in;
      answer.sector_inside = sector_res;
      answer.sector_done   = v.sector_last;
      pending.push_back(answer);

      ring_start = 1'b1;
      parity = 1'b0;
      hit = 1'b0;
      outer = v.sector_last;
    endfunction

    function void check_result(pipwh_pkg::result_t got);
      pipwh_pkg::result_t want;
      string              names[3];
      names = '{"ring_inside", "sector_inside", "sector_done"};
      if (pending.size() == 0) begin
        $display("%0t: result %b arrived with no answer waiting", $time, got);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      results++;
      if (got.ring_inside) rings_inside++;
      if (got.sector_done) sectors++;
      for (int i = 0; i < 3; i++) begin
        if (want[2-i] !== got[2-i]) begin
          $display("%0t: %s expected %b actual %b", $time, names[i], want[2-i], got[2-i]);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  int   sent;
  int   src_burst;
  int   snk_burst;

  ring_scoreboard board;

  pipwh_vertex_if #(.COORD_BITS(CW)) in_if ();
  pipwh_result_if                    out_if ();

  point_in_polygon_with_holes_core #(
    .COORD_BITS(CW)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  always #(CLK_HALF) clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Gap before the next transaction on one side. Most draws are uniform random
  // gaps, but now and then a burst of back-to-back transactions is started so
  // that the core also sees long stretches without any idling.
  function automatic int draw_gap(ref int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic int offset(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic vertex_t make_vertex(int vx, int vy, int px, int py, bit rl, bit sl);
    vertex_t v;
    v.vx = CW'(vx); v.vy = CW'(vy); v.px = CW'(px); v.py = CW'(py);
    v.ring_last = rl;
    v.sector_last = sl;
    return v;
  endfunction

  // Drives one vertex transaction. Fields change at the falling edge, and
  // acceptance is seen at the rising edge where valid and ready are both high.
  // With no gap, valid simply stays high into the next transaction.
  task automatic send_vertex(vertex_t v);
    int gap;
    gap = draw_gap(src_burst);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.vertex_x    <= v.vx;
    in_if.vertex_y    <= v.vy;
    in_if.point_x     <= v.px;
    in_if.point_y     <= v.py;
    in_if.ring_last   <= v.ring_last;
    in_if.sector_last <= v.sector_last;
    in_if.valid       <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    board.note_vertex(v);
    sent++;
  endtask

  // Builds and sends one ring around (cx,cy) of size s (a wild ring's vertices lie
  // anywhere). The point may drift now and then, and sector_last is sometimes set
  // on a vertex that does not end a ring, which the core must ignore.
  task automatic send_ring(ring_kind_t kind, int cx, int cy, int s, bit ends_sector,
                           inout int px, inout int py);
    int xs[8];
    int ys[8];
    int n, a, b, k;
    bit rev;
    bit rl;
    bit sl;
    n = 0;
    rev = 1'($urandom_range(0, 1));
    case (kind)
      RING_RECT: begin
        a = $urandom_range(1, s);
        b = $urandom_range(1, s);
        n = 4;
        xs[0] = cx - a; ys[0] = cy - b;
        xs[1] = cx + a; ys[1] = cy - b;
        xs[2] = cx + a; ys[2] = cy + b;
        xs[3] = cx - a; ys[3] = cy + b;
      end
      RING_SCATTER: begin
        n = $urandom_range(3, 8);
        for (int i = 0; i < n; i++) begin
          xs[i] = cx + offset(s);
          ys[i] = cy + offset(s);
        end
      end
      RING_WILD: begin
        n = $urandom_range(3, 6);
        for (int i = 0; i < n; i++) begin
          xs[i] = int'($urandom);
          ys[i] = int'($urandom);
        end
      end
      default: begin
        n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++) begin
          xs[i] = cx + offset(s);
          ys[i] = cy + offset(s);
        end
      end
    endcase
    for (int i = 0; i < n; i++) begin
      k = rev ? n - 1 - i : i;
      if ($urandom_range(0, 39) == 0) begin
        px += offset(2);
        py += offset(2);
      end
      rl = (i == n - 1);
      sl = rl ? ends_sector : ($urandom_range(0, 15) == 0);
      send_vertex(make_vertex(xs[k], ys[k], px, py, rl, sl));
    end
  endtask

  // One random sector: an outer ring and up to two holes near its center.
  // Sizes are mostly tiny, so the point often lands inside a ring, on one of
  // its vertices, or exactly on one of its edges.
  task automatic send_sector();
    int s, cx, cy, px, py, holes, hs, pick;
    ring_kind_t outer_kind;
    ring_kind_t hole_kind;
    s  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 32);
    cx = offset(4000000);
    cy = offset(4000000);
    px = cx + offset(s);
    py = cy + offset(s);
    pick = $urandom_range(0, 19);
    if (pick < 8)       outer_kind = RING_RECT;
    else if (pick < 15) outer_kind = RING_SCATTER;
    else if (pick < 17) outer_kind = RING_WILD;
    else                outer_kind = RING_TINY;
    holes = $urandom_range(0, 2);
    send_ring(outer_kind, cx, cy, s, holes == 0, px, py);
    for (int h = 0; h < holes; h++) begin
      hs = (s > 1) ? s / 2 : 1;
      hole_kind = $urandom_range(0, 1) ? RING_RECT : RING_SCATTER;
      send_ring(hole_kind, cx + offset(s / 4), cy + offset(s / 4), hs, h == holes - 1,
                px, py);
    end
  endtask

  // Result side: ready idles at random, and every accepted result is checked.
  initial begin
    int gap;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = draw_gap(snk_burst);
      @(negedge clk);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      board.check_result({out_if.ring_inside, out_if.sector_inside, out_if.sector_done});
    end
  end

  initial begin
    int directed;
    rst_n = 1'b0;
    sent = 0;
    src_burst = 0;
    snk_burst = 0;
    board = new();
    in_if.valid       = 1'b0;
    in_if.vertex_x    = '0;
    in_if.vertex_y    = '0;
    in_if.point_x     = '0;
    in_if.point_y     = '0;
    in_if.ring_last   = 1'b0;
    in_if.sector_last = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // A plain square (100 by 100 in Q16.8) with the point at its center:
    // a one-ring sector that answers inside.
    send_vertex(make_vertex(0,     0,     12800, 12800, 1'b0, 1'b0));
    send_vertex(make_vertex(25600, 0,     12800, 12800, 1'b0, 1'b0));
    send_vertex(make_vertex(25600, 25600, 12800, 12800, 1'b0, 1'b0));
    send_vertex(make_vertex(0,     25600, 12800, 12800, 1'b1, 1'b1));
    // The same square with a hole around the point: the hole clears the sector.
    send_vertex(make_vertex(0,     0,     12800, 12800, 1'b0, 1'b0));
    send_vertex(make_vertex(25600, 0,     12800, 12800, 1'b0, 1'b0));
    send_vertex(make_vertex(25600, 25600, 12800, 12800, 1'b0, 1'b0));
    send_vertex(make_vertex(0,     25600, 12800, 12800, 1'b1, 1'b0));
    send_vertex(make_vertex(6400,  6400,  12800, 12800, 1'b0, 1'b0));
    send_vertex(make_vertex(6400,  19200, 12800, 12800, 1'b0, 1'b0));
    send_vertex(make_vertex(19200, 19200, 12800, 12800, 1'b0, 1'b0));
    send_vertex(make_vertex(19200, 6400,  12800, 12800, 1'b1, 1'b1));
    // A ring of one vertex, sitting on the point.
    send_vertex(make_vertex(0, 0, 0, 0, 1'b1, 1'b1));
    // A ring of two vertices: its one edge is counted twice.
    send_vertex(make_vertex(-100, -100, 0, 0, 1'b0, 1'b0));
    send_vertex(make_vertex(100,  100,  0, 0, 1'b1, 1'b1));
    // Full-scale triangle around the origin. The first vertex carries a stray
    // sector_last without ring_last.
    send_vertex(make_vertex(-8388608, -8388608, 0, 0, 1'b0, 1'b1));
    send_vertex(make_vertex(8388607,  -8388608, 0, 0, 1'b0, 1'b0));
    send_vertex(make_vertex(0,        8388607,  0, 0, 1'b1, 1'b1));
    // The same triangle with the point on one of its corners.
    send_vertex(make_vertex(-8388608, -8388608, 8388607, -8388608, 1'b0, 1'b0));
    send_vertex(make_vertex(8388607,  -8388608, 8388607, -8388608, 1'b0, 1'b0));
    send_vertex(make_vertex(0,        8388607,  8388607, -8388608, 1'b1, 1'b1));
    // The same triangle with the point at the opposite extreme, outside the ray count.
    send_vertex(make_vertex(-8388608, -8388608, -8388608, 8388607, 1'b0, 1'b0));
    send_vertex(make_vertex(8388607,  -8388608, -8388608, 8388607, 1'b0, 1'b0));
    send_vertex(make_vertex(0,        8388607,  -8388608, 8388607, 1'b1, 1'b1));
    directed = sent;

    while (sent < directed + RANDOM_ITEMS) send_sector();

    @(negedge clk);
    in_if.valid <= 1'b0;

    // Wait for every predicted result, then wait DRAIN_CYCLES more to catch strays.
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d vertices (%0d directed); checked %0d ring results, %0d inside.",
             sent, directed, board.results, board.rings_inside);
    $display("Sectors completed: %0d.", board.sectors);
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
